FILE: rtl/texture_memory_load_writer_defines.svh
// assertion macros for the texture memory load writer
// no dependencies; assertions drop out when SYNTH is defined
`ifndef TEXTURE_MEMORY_LOAD_WRITER_DEFINES_SVH
`define TEXTURE_MEMORY_LOAD_WRITER_DEFINES_SVH
`ifndef SYNTH
`define TMLW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("tmlw assertion failed");
`define TMLW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmlw implication failed");
`else
`define TMLW_ASSERT(lbl, cond)
`define TMLW_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: rtl/tmlw_pkg.sv
// shared types and constants for the texture memory load writer
// no dependencies
`default_nettype none
package tmlw_pkg;

  localparam int unsigned ROWS_PER_BANK = 256;
  localparam int unsigned ROW_W         = $clog2(ROWS_PER_BANK);
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned QPTR_W        = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    LK_TILE  = 2'd0,
    LK_BLOCK = 2'd1,
    LK_TLUT  = 2'd2,
    LK_SPARE = 2'd3
  } load_kind_e;

  typedef enum logic [2:0] {
    LAY_4BPP  = 3'd0,
    LAY_8BPP  = 3'd1,
    LAY_16BPP = 3'd2,
    LAY_32BPP = 3'd3,
    LAY_YUV   = 3'd4,
    LAY_RGBA  = 3'd5,
    LAY_SP6   = 3'd6,
    LAY_SP7   = 3'd7
  } layout_e;

  localparam logic [1:0] SZ_4BPP = 2'd0;

  typedef enum logic [2:0] {
    REG_LOAD_KIND  = 3'd0,
    REG_IMG_SIZE   = 3'd1,
    REG_LAYOUT     = 3'd2,
    REG_ROW_PITCH  = 3'd3,
    REG_BASE_WORD  = 3'd4,
    REG_S_LOW      = 3'd5,
    REG_T_LOW      = 3'd6,
    REG_T_SLOPE    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    load_kind_e  load_kind;
    logic [1:0]  img_size;
    layout_e     layout;
    logic [8:0]  row_pitch;
    logic [8:0]  base_word;
    logic [11:0] s_low;
    logic [11:0] t_low;
    logic [11:0] t_slope;
  } cfg_t;

  typedef struct packed {
    logic [63:0] data;
    logic [10:0] first;
    logic        odd;
    logic        hw1;
    logic        nop;
  } step_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage
`default_nettype wire

FILE: rtl/tmlw_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module tmlw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/tmlw_front.sv
// front pipeline: s/t coordinates, row address and first halfword per step
// depends on tmlw_pkg
`default_nettype none
module tmlw_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tmlw_pkg::cfg_t    cfg_i,
  input  wire logic              clearing_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [63:0]       data_word_i,
  input  wire logic [9:0]        line_offset_i,
  input  wire logic [11:0]       step_index_i,
  input  wire logic              source_odd_i,
  input  wire tmlw_pkg::fifo_st_t fifo_st_i,
  output logic                   push_o,
  output tmlw_pkg::step_t        push_data_o
);
  logic block, tlut, coarse, en;
  logic [1:0] hshift;

  logic               v1_q, v2_q;
  logic signed [17:0] s1_q;
  logic [23:0]        tmul_q;
  logic [9:0]         line_q;
  logic [63:0]        data1_q, data2_q;
  logic               src1_q, src2_q;
  logic [10:0]        hw_q;
  logic [8:0]         t9_q;
  logic               odd_q;

  logic [3:0]         sh;
  logic [19:0]        sprod;
  logic [15:0]        ssum;
  logic signed [17:0] s_diff, s_c;
  logic [15:0]        t_line, tsum;
  logic signed [17:0] t_diff, t_c, s_h;
  logic [17:0]        rprod;
  logic [9:0]         row;
  logic [11:0]        fsum;

  assign block  = cfg_i.load_kind == tmlw_pkg::LK_BLOCK;
  assign tlut   = cfg_i.load_kind == tmlw_pkg::LK_TLUT;
  assign coarse = block || tlut;
  assign hshift = (cfg_i.layout == tmlw_pkg::LAY_8BPP || cfg_i.layout == tmlw_pkg::LAY_YUV) ?
                  2'd1 : ((cfg_i.layout == tmlw_pkg::LAY_4BPP) ? 2'd2 : 2'd0);

  assign en         = !(v2_q && fifo_st_i.full);
  assign in_ready_o = en && !clearing_i;

  // stage 1: s coordinate and t slope product
  always_comb begin
    sh     = block ? (4'd7 - {2'b00, cfg_i.img_size}) : (4'd9 - {2'b00, cfg_i.img_size});
    sprod  = {8'b0, step_index_i} << sh;
    ssum   = {1'b0, cfg_i.s_low, 3'b000} + sprod[15:0];
    s_diff = $signed({{2{ssum[15]}}, ssum}) - $signed({3'b000, cfg_i.s_low, 3'b000});
    s_c    = coarse ? (s_diff >>> 3) : (s_diff >>> 5);
  end

  // stage 2: t coordinate and halfword offset
  always_comb begin
    t_line = {1'b0, cfg_i.t_low, 3'b000} + {1'b0, line_q, 5'b00000};
    tsum   = t_line + tmul_q[23:8];
    t_diff = $signed({{2{tsum[15]}}, tsum}) - $signed({3'b000, cfg_i.t_low, 3'b000});
    t_c    = coarse ? (t_diff >>> 3) : (t_diff >>> 5);
    s_h    = s1_q >>> hshift;
  end

  // stage 3: row and first halfword
  always_comb begin
    rprod = cfg_i.row_pitch * t9_q;
    row   = {1'b0, rprod[8:0]} + {1'b0, cfg_i.base_word};
    fsum  = {row, 2'b00} + {1'b0, hw_q};
    push_o = v2_q && !fifo_st_i.full;
    push_data_o.first = {fsum[10:2], 1'b0, fsum[0]};
    push_data_o.odd   = odd_q;
    push_data_o.hw1   = hw_q[1];
    push_data_o.nop   = cfg_i.img_size == tmlw_pkg::SZ_4BPP;
    push_data_o.data  = (tlut && !src2_q) ? {4{data2_q[63:48]}} : data2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && in_ready_o;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= s_c;
      tmul_q  <= block ? (step_index_i * cfg_i.t_slope) : 24'd0;
      line_q  <= line_offset_i;
      data1_q <= data_word_i;
      src1_q  <= source_odd_i;
      hw_q    <= s_h[10:0];
      t9_q    <= t_c[8:0];
      odd_q   <= t_c[0];
      data2_q <= data1_q;
      src2_q  <= src1_q;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tmlw_fifo.sv
// short queue between the front pipeline and the memory writer
// depends on tmlw_pkg
`default_nettype none
module tmlw_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tmlw_pkg::step_t    push_data_i,
  input  wire logic               pop_i,
  output tmlw_pkg::step_t         head_o,
  output tmlw_pkg::fifo_st_t      st_o
);
  tmlw_pkg::step_t               mem_q [tmlw_pkg::QDEPTH];
  logic [tmlw_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [tmlw_pkg::QPTR_W:0]     cnt_q;

  assign st_o.full  = cnt_q == (tmlw_pkg::QPTR_W+1)'(tmlw_pkg::QDEPTH);
  assign st_o.empty = cnt_q == '0;
  assign head_o     = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + {{tmlw_pkg::QPTR_W{1'b0}}, push_i} - {{tmlw_pkg::QPTR_W{1'b0}}, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tmlw_back.sv
// back end: bank-swizzled halfword writes into eight bank rams, result register
// depends on tmlw_pkg and tmlw_ram
`default_nettype none
module tmlw_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tmlw_pkg::cfg_t     cfg_i,
  input  wire tmlw_pkg::fifo_st_t fifo_st_i,
  input  wire tmlw_pkg::step_t    head_i,
  output logic                    pop_o,
  output logic                    clearing_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    upper_half_o,
  output logic [10:0]             first_halfword_o
);
  localparam int unsigned RW = tmlw_pkg::ROW_W;

  logic          clearing_q;
  logic [RW-1:0] clr_q;

  logic          yuv, rgba, split, whole, wr;
  logic [1:0]    swap, p, bx;
  logic [10:0]   a;
  logic [RW-1:0] brow [4];
  logic [63:0]   wd;
  logic [31:0]   lo, hi;

  logic          ram_we [8];
  logic [RW-1:0] ram_a  [8];
  logic [15:0]   ram_d  [8];

  assign clearing_o = clearing_q;
  assign pop_o      = !fifo_st_i.empty && !clearing_q && (!out_valid_o || out_ready_i);

  always_comb begin
    yuv   = cfg_i.layout == tmlw_pkg::LAY_YUV;
    rgba  = cfg_i.layout == tmlw_pkg::LAY_RGBA;
    split = yuv || rgba;
    whole = !head_i.first[0] && !split;
    wr    = pop_o && !head_i.nop;
    swap  = {head_i.odd, 1'b0};
    bx    = 2'd0;
    wd    = head_i.odd ? head_i.data : {head_i.data[31:0], head_i.data[63:32]};
    p     = (head_i.hw1 ^ head_i.odd) ? 2'd2 : 2'd0;
    if (yuv) begin
      lo = {head_i.data[63:56], head_i.data[47:40], head_i.data[31:24], head_i.data[15:8]};
      hi = {head_i.data[55:48], head_i.data[39:32], head_i.data[23:16], head_i.data[7:0]};
    end else begin
      lo = {head_i.data[63:48], head_i.data[31:16]};
      hi = {head_i.data[47:32], head_i.data[15:0]};
    end
    for (int i = 0; i < 4; i++) begin
      brow[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      a = (head_i.first + 11'(i)) ^ {9'b0, swap};
      brow[a[1:0]] = a[9:2];
    end
    for (int k = 0; k < 8; k++) begin
      ram_we[k] = clearing_q;
      ram_a[k]  = clr_q;
      ram_d[k]  = '0;
    end
    if (wr) begin
      if (whole) begin
        for (int b = 0; b < 4; b++) begin
          ram_we[{head_i.first[10], 2'(b)}] = 1'b1;
          ram_a[{head_i.first[10], 2'(b)}]  = head_i.first[9:2];
          ram_d[{head_i.first[10], 2'(b)}]  = wd[16*b +: 16];
        end
      end else if (split) begin
        ram_we[{1'b0, p ^ 2'd1}] = 1'b1;
        ram_a[{1'b0, p ^ 2'd1}]  = brow[p];
        ram_d[{1'b0, p ^ 2'd1}]  = lo[31:16];
        ram_we[{1'b1, p ^ 2'd1}] = 1'b1;
        ram_a[{1'b1, p ^ 2'd1}]  = brow[p];
        ram_d[{1'b1, p ^ 2'd1}]  = hi[31:16];
        ram_we[{1'b0, p}]        = 1'b1;
        ram_a[{1'b0, p}]         = brow[p + 2'd1];
        ram_d[{1'b0, p}]         = lo[15:0];
        ram_we[{1'b1, p}]        = 1'b1;
        ram_a[{1'b1, p}]         = brow[p + 2'd1];
        ram_d[{1'b1, p}]         = hi[15:0];
      end else begin
        for (int b = 0; b < 4; b++) begin
          bx = 2'(b) ^ swap;
          ram_we[{head_i.first[10], 2'(b) ^ 2'd1}] = 1'b1;
          ram_a[{head_i.first[10], 2'(b) ^ 2'd1}]  = brow[b];
          ram_d[{head_i.first[10], 2'(b) ^ 2'd1}]  = head_i.data[16*(3 - bx) +: 16];
        end
      end
    end
  end

  for (genvar k = 0; k < 8; k++) begin : g_bank
    tmlw_ram #(
      .Width(16),
      .Depth(tmlw_pkg::ROWS_PER_BANK)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we[k]),
      .waddr_i(ram_a[k]),
      .wdata_i(ram_d[k]),
      .raddr_i(ram_a[k]),
      .rdata_o()
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == {RW{1'b1}}) clearing_q <= 1'b0;
      end
      if (pop_o) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      upper_half_o     <= !head_i.nop && (split || head_i.first[10]);
      first_halfword_o <= head_i.nop ? 11'd0 : head_i.first;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/texture_memory_load_writer.sv
// throughput: one step per cycle while the queue has room, the output is free
// and no clearing pass runs; two-register front pipeline, 4-entry queue, result
// register; the back end writes four of the eight bank rams per step unless a nop
// reset: registers take their reset values, then a clearing pass over all 256 rows
// of each bank zeroes the texture memory while no input transaction is taken
`default_nettype none
`include "texture_memory_load_writer_defines.svh"
module texture_memory_load_writer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] data_word_i,
  input  wire logic [9:0]  line_offset_i,
  input  wire logic [11:0] step_index_i,
  input  wire logic        source_odd_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             upper_half_o,
  output logic [10:0]      first_halfword_o
);
  tmlw_pkg::cfg_t     cfg_q;
  tmlw_pkg::fifo_st_t fifo_st;
  tmlw_pkg::step_t    push_data, head;
  logic               push, pop, clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_kind  <= tmlw_pkg::LK_TILE;
      cfg_q.img_size   <= 2'd2;
      cfg_q.layout     <= tmlw_pkg::LAY_16BPP;
      cfg_q.row_pitch  <= '0;
      cfg_q.base_word  <= '0;
      cfg_q.s_low      <= '0;
      cfg_q.t_low      <= '0;
      cfg_q.t_slope    <= '0;
    end else if (cfg_we_i) begin
      unique case (tmlw_pkg::reg_idx_e'(cfg_idx_i))
        tmlw_pkg::REG_LOAD_KIND:  cfg_q.load_kind  <= tmlw_pkg::load_kind_e'(cfg_data_i[1:0]);
        tmlw_pkg::REG_IMG_SIZE:   cfg_q.img_size   <= cfg_data_i[1:0];
        tmlw_pkg::REG_LAYOUT:     cfg_q.layout     <= tmlw_pkg::layout_e'(cfg_data_i[2:0]);
        tmlw_pkg::REG_ROW_PITCH:  cfg_q.row_pitch  <= cfg_data_i[8:0];
        tmlw_pkg::REG_BASE_WORD:  cfg_q.base_word  <= cfg_data_i[8:0];
        tmlw_pkg::REG_S_LOW:      cfg_q.s_low      <= cfg_data_i;
        tmlw_pkg::REG_T_LOW:      cfg_q.t_low      <= cfg_data_i;
        tmlw_pkg::REG_T_SLOPE:    cfg_q.t_slope    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tmlw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .clearing_i   (clearing),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_word_i  (data_word_i),
    .line_offset_i(line_offset_i),
    .step_index_i (step_index_i),
    .source_odd_i (source_odd_i),
    .fifo_st_i    (fifo_st),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tmlw_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .head_o     (head),
    .st_o       (fifo_st)
  );

  tmlw_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .fifo_st_i       (fifo_st),
    .head_i          (head),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .upper_half_o    (upper_half_o),
    .first_halfword_o(first_halfword_o)
  );

  `TMLW_ASSERT_IMP(a_no_accept_clearing, clearing, !in_ready_o)
  `TMLW_ASSERT_IMP(a_no_result_clearing, clearing, !out_valid_o)
  `TMLW_ASSERT(a_fifo_status, !(fifo_st.full && fifo_st.empty))
  `TMLW_ASSERT_IMP(a_pop_needs_entry, pop, !fifo_st.empty)
endmodule
`default_nettype wire
